// ----- rtl/core/cnv_pkg.sv -----
// shared types, constants and helper functions for the 2-d convolution unit
// no dependencies
package cnv_pkg;

	localparam int POS_W = 16;
	typedef logic signed [POS_W-1:0] pos_t;

	localparam logic [1:0] SHAPE_FULL  = 2'd0;
	localparam logic [1:0] SHAPE_SAME  = 2'd1;
	localparam logic [1:0] SHAPE_VALID = 2'd2;

	typedef enum logic [2:0] {
		REG_SHAPE_MODE    = 3'd0,
		REG_IMAGE_ROWS    = 3'd1,
		REG_IMAGE_COLS    = 3'd2,
		REG_KERNEL_HEIGHT = 3'd3,
		REG_KERNEL_WIDTH  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]  shape_mode;
		logic [10:0] image_rows;
		logic [10:0] image_cols;
		logic [2:0]  kernel_height;
		logic [2:0]  kernel_width;
	} cfg_t;

	// one entry of the front-to-back queue
	typedef struct packed {
		logic               is_sample;
		logic [4:0]         coef_index;
		logic signed [15:0] coef_value;
		logic signed [15:0] sample;
		pos_t               row;
		pos_t               col;
		logic [3:0]         row_mod;
		logic               emit;
		pos_t               plo;
		pos_t               phi;
		pos_t               qlo;
		pos_t               qhi;
		pos_t               p0;
		pos_t               q0;
		pos_t               p_last;
		pos_t               q_last;
		pos_t               kh;
		pos_t               kw;
	} task_t;

	typedef struct packed {
		logic [10:0]        out_row;
		logic [10:0]        out_col;
		logic signed [39:0] value;
		logic               last;
		logic               frame_done;
	} result_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_OSTART,
		B_TAP,
		B_DRAIN,
		B_RESULT
	} back_state_t;

	function automatic pos_t clamp_size(logic [10:0] v, int hi);
		pos_t r;
		if (v == 11'd0) begin
			r = pos_t'(1);
		end else if (int'(v) > hi) begin
			r = pos_t'(hi);
		end else begin
			r = pos_t'(v);
		end
		return r;
	endfunction

	function automatic pos_t region_first(logic [1:0] mode, pos_t k);
		pos_t r;
		case (mode)
			SHAPE_SAME:  r = (k - pos_t'(1)) - ((k - pos_t'(1)) >>> 1);
			SHAPE_VALID: r = k - pos_t'(1);
			default:     r = pos_t'(0);
		endcase
		return r;
	endfunction

	function automatic pos_t region_count(logic [1:0] mode, pos_t n, pos_t k);
		pos_t r;
		case (mode)
			SHAPE_SAME:  r = n;
			SHAPE_VALID: r = n - k + pos_t'(1);
			default:     r = n + k - pos_t'(1);
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/cnv_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module cnv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 5120
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- rtl/core/cnv_fifo.sv -----
// small synchronous queue of any packed type
// no dependencies
module cnv_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     din,
	output logic full,
	input  logic pop,
	output T     dout,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	T               mem_q [DEPTH];
	logic [PW-1:0]  head_q;
	logic [PW-1:0]  tail_q;
	logic [PW:0]    count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == (PW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[head_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[tail_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);
			end
			if (do_pop) begin
				head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ----- rtl/core/cnv_front.sv -----
// front end: tracks the raster position and works out which outputs each sample completes
// depends on cnv_pkg
module cnv_front import cnv_pkg::*; #(
	parameter int MAX_KERNEL = 5,
	parameter int MAX_COLS   = 1024,
	parameter int MAX_ROWS   = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               push,
	input  logic               action,
	input  logic [4:0]         coef_index,
	input  logic signed [15:0] coef_value,
	input  logic signed [15:0] sample,
	input  logic               q_full,
	output logic               q_push,
	output task_t              q_data
);
	localparam int RCW = $clog2(MAX_ROWS);
	localparam int CCW = $clog2(MAX_COLS);
	localparam int KMW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

	logic [RCW-1:0] row_q;
	logic [CCW-1:0] col_q;
	logic [KMW-1:0] rmod_q;

	pos_t rows_c, cols_c, kh_c, kw_c;
	pos_t r, c, p0, q0, dr, dc, p_last, q_last;
	pos_t plo, phi_raw, phi, qlo, qhi_raw, qhi;
	logic restart;
	logic [KMW-1:0] rm;
	pos_t c_next, r_next;

	assign rows_c = clamp_size(cfg.image_rows, MAX_ROWS);
	assign cols_c = clamp_size(cfg.image_cols, MAX_COLS);
	assign kh_c   = clamp_size({8'd0, cfg.kernel_height}, MAX_KERNEL);
	assign kw_c   = clamp_size({8'd0, cfg.kernel_width}, MAX_KERNEL);

	// a register change may leave the position outside the image
	assign restart = (pos_t'(row_q) >= rows_c) || (pos_t'(col_q) >= cols_c);
	assign r  = restart ? pos_t'(0) : pos_t'(row_q);
	assign c  = restart ? pos_t'(0) : pos_t'(col_q);
	assign rm = restart ? '0 : rmod_q;

	assign p0     = region_first(cfg.shape_mode, kh_c);
	assign q0     = region_first(cfg.shape_mode, kw_c);
	assign dr     = region_count(cfg.shape_mode, rows_c, kh_c);
	assign dc     = region_count(cfg.shape_mode, cols_c, kw_c);
	assign p_last = p0 + dr - pos_t'(1);
	assign q_last = q0 + dc - pos_t'(1);

	// last row and last column also finish the border outputs past the image
	assign phi_raw = (r == rows_c - pos_t'(1)) ? rows_c + kh_c - pos_t'(2) : r;
	assign qhi_raw = (c == cols_c - pos_t'(1)) ? cols_c + kw_c - pos_t'(2) : c;
	assign plo = (r < p0) ? p0 : r;
	assign qlo = (c < q0) ? q0 : c;
	assign phi = (phi_raw > p_last) ? p_last : phi_raw;
	assign qhi = (qhi_raw > q_last) ? q_last : qhi_raw;

	assign c_next = c + pos_t'(1);
	assign r_next = r + pos_t'(1);

	assign q_push = push && !q_full;

	always_comb begin
		q_data            = '0;
		q_data.is_sample  = action;
		q_data.coef_index = coef_index;
		q_data.coef_value = coef_value;
		q_data.sample     = sample;
		q_data.row        = r;
		q_data.col        = c;
		q_data.row_mod    = 4'(rm);
		q_data.emit       = (plo <= phi) && (qlo <= qhi);
		q_data.plo        = plo;
		q_data.phi        = phi;
		q_data.qlo        = qlo;
		q_data.qhi        = qhi;
		q_data.p0         = p0;
		q_data.q0         = q0;
		q_data.p_last     = p_last;
		q_data.q_last     = q_last;
		q_data.kh         = kh_c;
		q_data.kw         = kw_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			rmod_q <= '0;
		end else if (q_push && action) begin
			if (c_next >= cols_c) begin
				col_q <= '0;
				if (r_next >= rows_c) begin
					row_q  <= '0;
					rmod_q <= '0;
				end else begin
					row_q  <= RCW'(r_next);
					rmod_q <= (rm == KMW'(MAX_KERNEL - 1)) ? '0 : rm + KMW'(1);
				end
			end else begin
				col_q  <= CCW'(c_next);
				row_q  <= RCW'(r);
				rmod_q <= rm;
			end
		end
	end
endmodule

// ----- rtl/core/cnv_back.sv -----
// back end: stores coefficients and lines, then runs one multiply-accumulate per tap
// depends on cnv_pkg, cnv_ram
module cnv_back import cnv_pkg::*; #(
	parameter int MAX_KERNEL = 5,
	parameter int MAX_COLS   = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	input  task_t   t_in,
	input  logic    t_empty,
	output logic    t_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res_data
);
	localparam int NCOEF = MAX_KERNEL * MAX_KERNEL;
	localparam int CIW   = (NCOEF > 1) ? $clog2(NCOEF) : 1;
	localparam int DEPTH = MAX_KERNEL * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int KMW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

	back_state_t state_q, state_d;

	logic signed [15:0] coef_q [NCOEF];
	task_t          cur_q;
	pos_t           p_q, q_q, s_q, t_q, slo_q, tlo_q;
	logic [KMW-1:0] smod_q;
	logic [3:0]     i_q, j_q;
	logic signed [39:0] acc_q;

	logic               v_s1, last_s1, v_s2, last_s2;
	logic signed [15:0] coef_s1;
	logic signed [31:0] prod_s2;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [15:0]        ram_rdata;
	logic               last_tap, last_out;
	pos_t               slo_c, tlo_c;

	assign last_tap = (s_q == slo_q) && (t_q == tlo_q);
	assign last_out = (p_q == cur_q.phi) && (q_q == cur_q.qhi);
	assign slo_c = (p_q - cur_q.kh + pos_t'(1) < 0) ? pos_t'(0) : p_q - cur_q.kh + pos_t'(1);
	assign tlo_c = (q_q - cur_q.kw + pos_t'(1) < 0) ? pos_t'(0) : q_q - cur_q.kw + pos_t'(1);

	assign ram_waddr = AW'(KMW'(t_in.row_mod)) * AW'(MAX_COLS) + AW'(t_in.col);
	assign ram_raddr = AW'(smod_q) * AW'(MAX_COLS) + AW'(t_q);

	cnv_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (t_in.sample),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!t_empty && t_in.is_sample && t_in.emit) begin
					state_d = B_OSTART;
				end
			end
			B_OSTART: state_d = B_TAP;
			B_TAP: begin
				if (last_tap) begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: begin
				if (v_s2 && last_s2) begin
					state_d = B_RESULT;
				end
			end
			B_RESULT: begin
				if (!res_full) begin
					state_d = last_out ? B_IDLE : B_OSTART;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		t_pop    = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		res_push = 1'b0;
		case (state_q)
			B_IDLE: begin
				t_pop  = !t_empty;
				ram_we = !t_empty && t_in.is_sample;
			end
			B_TAP:    ram_re   = 1'b1;
			B_RESULT: res_push = !res_full;
			default: begin
				t_pop = 1'b0;
			end
		endcase
	end

	always_comb begin
		res_data            = '0;
		res_data.out_row    = 11'(p_q - cur_q.p0);
		res_data.out_col    = 11'(q_q - cur_q.q0);
		res_data.value      = acc_q;
		res_data.last       = last_out;
		res_data.frame_done = (p_q == cur_q.p_last) && (q_q == cur_q.q_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= ram_re;
			v_s2    <= v_s1;
		end
	end

	// tap walk goes from the newest sample back toward the window corner
	always_ff @(posedge clk) begin
		last_s1 <= last_tap;
		coef_s1 <= coef_q[CIW'(int'(i_q) * MAX_KERNEL + int'(j_q))];
		last_s2 <= last_s1;
		prod_s2 <= $signed(ram_rdata) * coef_s1;
		if (v_s2) begin
			acc_q <= acc_q + 40'(prod_s2);
		end
		case (state_q)
			B_IDLE: begin
				if (!t_empty && !t_in.is_sample && int'(t_in.coef_index) < NCOEF) begin
					coef_q[CIW'(t_in.coef_index)] <= t_in.coef_value;
				end
				if (!t_empty && t_in.is_sample) begin
					cur_q <= t_in;
					p_q   <= t_in.plo;
					q_q   <= t_in.qlo;
				end
			end
			B_OSTART: begin
				s_q    <= cur_q.row;
				smod_q <= KMW'(cur_q.row_mod);
				t_q    <= cur_q.col;
				i_q    <= 4'(p_q - cur_q.row);
				j_q    <= 4'(q_q - cur_q.col);
				slo_q  <= slo_c;
				tlo_q  <= tlo_c;
				acc_q  <= '0;
			end
			B_TAP: begin
				if (t_q == tlo_q) begin
					t_q    <= cur_q.col;
					j_q    <= 4'(q_q - cur_q.col);
					s_q    <= s_q - pos_t'(1);
					smod_q <= (smod_q == '0) ? KMW'(MAX_KERNEL - 1) : smod_q - KMW'(1);
					i_q    <= i_q + 4'd1;
				end else begin
					t_q <= t_q - pos_t'(1);
					j_q <= j_q + 4'd1;
				end
			end
			B_RESULT: begin
				if (!res_full && !last_out) begin
					if (q_q == cur_q.qhi) begin
						q_q <= cur_q.qlo;
						p_q <= p_q + pos_t'(1);
					end else begin
						q_q <= q_q + pos_t'(1);
					end
				end
			end
			default: begin
				s_q <= s_q;
			end
		endcase
	end
endmodule

// ----- rtl/core/conv2d_full_same_valid_unit.sv -----
// top level of the streaming 2-d convolution unit with full, same and valid regions
// depends on cnv_pkg, cnv_front, cnv_fifo, cnv_back
// A coefficient load, or a sample that completes no output, is taken by the back end in idle,
// so such items stream at one per cycle while the back end is idle and its queue is not empty.
// A sample that completes outputs keeps the back end busy: per output it runs set-up, a walk
// over each tap inside the image (at most kh*kw), pipeline drain and hand-off, since the back
// end has one line store read port and one multiply-accumulate that every tap goes through.
// A four-entry queue between front and back and another on the result side absorb bursts.
// The line store needs no clearing; it is always written before any output reads it.
module conv2d_full_same_valid_unit import cnv_pkg::*; #(
	parameter int MAX_KERNEL = 5,
	parameter int MAX_COLS   = 1024,
	parameter int MAX_ROWS   = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [10:0]        cfg_wdata,
	input  logic               push,
	output logic               full,
	input  logic               action,
	input  logic [4:0]         coef_index,
	input  logic signed [15:0] coef_value,
	input  logic signed [15:0] sample,
	output logic               empty,
	input  logic               pop,
	output logic [10:0]        out_row,
	output logic [10:0]        out_col,
	output logic signed [39:0] value,
	output logic               last,
	output logic               frame_done
);
	cfg_t    cfg_q;
	task_t   tq_din, tq_dout;
	logic    tq_push, tq_pop, tq_empty;
	result_t rq_din, rq_dout;
	logic    rq_push, rq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shape_mode    <= SHAPE_FULL;
			cfg_q.image_rows    <= 11'd1024;
			cfg_q.image_cols    <= 11'd1024;
			cfg_q.kernel_height <= 3'd3;
			cfg_q.kernel_width  <= 3'd3;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SHAPE_MODE:    cfg_q.shape_mode    <= cfg_wdata[1:0];
				REG_IMAGE_ROWS:    cfg_q.image_rows    <= cfg_wdata;
				REG_IMAGE_COLS:    cfg_q.image_cols    <= cfg_wdata;
				REG_KERNEL_HEIGHT: cfg_q.kernel_height <= cfg_wdata[2:0];
				REG_KERNEL_WIDTH:  cfg_q.kernel_width  <= cfg_wdata[2:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	cnv_front #(.MAX_KERNEL(MAX_KERNEL), .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.action     (action),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.sample     (sample),
		.q_full     (full),
		.q_push     (tq_push),
		.q_data     (tq_din)
	);

	cnv_fifo #(.T(task_t), .DEPTH(4)) u_task_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tq_push),
		.din    (tq_din),
		.full   (full),
		.pop    (tq_pop),
		.dout   (tq_dout),
		.empty  (tq_empty)
	);

	cnv_back #(.MAX_KERNEL(MAX_KERNEL), .MAX_COLS(MAX_COLS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.t_in     (tq_dout),
		.t_empty  (tq_empty),
		.t_pop    (tq_pop),
		.res_full (rq_full),
		.res_push (rq_push),
		.res_data (rq_din)
	);

	cnv_fifo #(.T(result_t), .DEPTH(4)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.din    (rq_din),
		.full   (rq_full),
		.pop    (pop),
		.dout   (rq_dout),
		.empty  (empty)
	);

	assign out_row    = rq_dout.out_row;
	assign out_col    = rq_dout.out_col;
	assign value      = rq_dout.value;
	assign last       = rq_dout.last;
	assign frame_done = rq_dout.frame_done;
endmodule

// ----- rtl/core/cnv_checker.sv -----
// port-level checks for the convolution unit, bound to the top level
// depends on conv2d_full_same_valid_unit
module cnv_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input logic [10:0]        out_row,
	input logic [10:0]        out_col,
	input logic signed [39:0] value,
	input logic               last,
	input logic               frame_done
);
	// the bottom-right element always closes the burst of the final sample
	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_done) |-> last)
		else $error("frame_done without last");

	// a waiting result stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(value) && $stable(out_row)
			&& $stable(out_col) && $stable(last) && $stable(frame_done)))
		else $error("result changed while stalled");

	// queues come out of reset drained
	a_reset_clear: assert property (@(posedge clk)
		$past(!arst_n) |-> (empty && !full))
		else $error("queues not clear after reset");
endmodule

bind conv2d_full_same_valid_unit cnv_checker u_cnv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.out_row    (out_row),
	.out_col    (out_col),
	.value      (value),
	.last       (last),
	.frame_done (frame_done)
);

// ----- sim/tb.sv -----
// self-checking testbench for conv2d_full_same_valid_unit
// depends on cnv_pkg and the rtl of the unit; predicts every result with its own model
`timescale 1ns / 1ps

module tb;
	import cnv_pkg::*;

	localparam int KMAX = 5;
	localparam int COLS_MAX = 1024;
	localparam int ROWS_MAX = 1024;
	localparam int SETTLE = 200;
	localparam int STALL_LIMIT = 5000;

	// holds the expected results and a copy of the convolution state
	class conv_scoreboard;
		logic [10:0] regs[5];
		int lines[KMAX][COLS_MAX];
		int coefs[KMAX*KMAX];
		int row_pos;
		int col_pos;
		result_t pending[$];
		int fails;

		function new();
			regs[REG_SHAPE_MODE] = 11'd0;
			regs[REG_IMAGE_ROWS] = 11'd1024;
			regs[REG_IMAGE_COLS] = 11'd1024;
			regs[REG_KERNEL_HEIGHT] = 11'd3;
			regs[REG_KERNEL_WIDTH] = 11'd3;
			row_pos = 0;
			col_pos = 0;
			fails = 0;
		endfunction

		function int fit(int v, int hi);
			if (v == 0) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [10:0] d);
			case (idx)
				REG_SHAPE_MODE: regs[idx] = d & 11'd3;
				REG_KERNEL_HEIGHT, REG_KERNEL_WIDTH: regs[idx] = d & 11'd7;
				default: regs[idx] = d;
			endcase
		endfunction

		function void span(int n, int k, output int first, output int cnt);
			case (regs[REG_SHAPE_MODE][1:0])
				SHAPE_SAME: begin
					first = (k - 1) - (k - 1) / 2;
					cnt = n;
				end
				SHAPE_VALID: begin
					first = k - 1;
					cnt = n - k + 1;
				end
				default: begin
					first = 0;
					cnt = n + k - 1;
				end
			endcase
		endfunction

		// accepted input transaction
		function void note(logic act, logic [4:0] idx, logic signed [15:0] cv,
				logic signed [15:0] smp);
			int nr, nc, kh, kw, p0, dr, q0, dc, plo, phi, qlo, qhi;
			int slo, shi, tlo, thi, cnt;
			longint acc;
			result_t res;
			if (!act) begin
				if (idx < KMAX*KMAX) coefs[idx] = cv;
				return;
			end
			nr = fit(regs[REG_IMAGE_ROWS], ROWS_MAX);
			nc = fit(regs[REG_IMAGE_COLS], COLS_MAX);
			kh = fit(regs[REG_KERNEL_HEIGHT], KMAX);
			kw = fit(regs[REG_KERNEL_WIDTH], KMAX);
			if (row_pos >= nr || col_pos >= nc) begin
				row_pos = 0;
				col_pos = 0;
			end
			lines[row_pos % KMAX][col_pos] = smp;
			span(nr, kh, p0, dr);
			span(nc, kw, q0, dc);
			plo = row_pos;
			phi = (row_pos == nr - 1) ? nr + kh - 2 : row_pos;
			qlo = col_pos;
			qhi = (col_pos == nc - 1) ? nc + kw - 2 : col_pos;
			if (plo < p0) plo = p0;
			if (phi > p0 + dr - 1) phi = p0 + dr - 1;
			if (qlo < q0) qlo = q0;
			if (qhi > q0 + dc - 1) qhi = q0 + dc - 1;
			cnt = 0;
			for (int p = plo; p <= phi; p++) begin
				for (int q = qlo; q <= qhi; q++) begin
					acc = 0;
					slo = (p - kh + 1 < 0) ? 0 : p - kh + 1;
					shi = (p < nr - 1) ? p : nr - 1;
					tlo = (q - kw + 1 < 0) ? 0 : q - kw + 1;
					thi = (q < nc - 1) ? q : nc - 1;
					for (int s = slo; s <= shi; s++)
						for (int t = tlo; t <= thi; t++)
							acc += longint'(lines[s % KMAX][t]) *
								longint'(coefs[(p - s) * KMAX + (q - t)]);
					res.out_row = 11'(p - p0);
					res.out_col = 11'(q - q0);
					res.value = acc[39:0];
					res.last = 1'b0;
					res.frame_done = (p - p0 == dr - 1) && (q - q0 == dc - 1);
					pending.push_back(res);
					cnt++;
				end
			end
			if (cnt > 0) pending[pending.size() - 1].last = 1'b1;
			col_pos++;
			if (col_pos >= nc) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= nr) row_pos = 0;
			end
		endfunction

		// accepted result transaction
		function void check(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("unexpected result row %0d col %0d", got.out_row, got.out_col);
				fails++;
				return;
			end
			want = pending.pop_front();
			if (got.out_row !== want.out_row) begin
				$error("out_row expected %0d actual %0d", want.out_row, got.out_row);
				fails++;
			end
			if (got.out_col !== want.out_col) begin
				$error("out_col expected %0d actual %0d", want.out_col, got.out_col);
				fails++;
			end
			if (got.value !== want.value) begin
				$error("value expected %0d actual %0d", want.value, got.value);
				fails++;
			end
			if (got.last !== want.last) begin
				$error("last expected %0b actual %0b", want.last, got.last);
				fails++;
			end
			if (got.frame_done !== want.frame_done) begin
				$error("frame_done expected %0b actual %0b", want.frame_done, got.frame_done);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = 3'd0;
	logic [10:0] cfg_wdata = 11'd0;
	logic push = 1'b0;
	logic full;
	logic action = 1'b0;
	logic [4:0] coef_index = 5'd0;
	logic signed [15:0] coef_value = 16'sd0;
	logic signed [15:0] sample = 16'sd0;
	logic empty;
	logic pop = 1'b0;
	logic [10:0] out_row;
	logic [10:0] out_col;
	logic signed [39:0] value;
	logic last;
	logic frame_done;

	conv_scoreboard sb = new();
	int stall_cycles = 0;
	int pop_wait = 0;
	bit pop_steady = 1'b0;
	bit send_steady = 1'b0;
	int item_count = 0;

	conv2d_full_same_valid_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.push(push), .full(full), .action(action), .coef_index(coef_index),
		.coef_value(coef_value), .sample(sample),
		.empty(empty), .pop(pop), .out_row(out_row), .out_col(out_col),
		.value(value), .last(last), .frame_done(frame_done)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// input and result transactions, sampled at the edge that accepts them
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) sb.note(action, coef_index, coef_value, sample);
			if (pop && !empty) sb.check('{out_row, out_col, value, last, frame_done});
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && stall_cycles >= STALL_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// receiver with random stalls, or steady when pop_steady is set
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop_wait > 0) begin
				pop <= 1'b0;
				pop_wait <= pop_wait - 1;
			end else begin
				pop <= 1'b1;
				if (!pop_steady) pop_wait <= pick_gap();
			end
		end
	end

	// the enable is dropped after each write and held low before the next, keeping the enable strobes apart
	task automatic write_reg(cfg_reg_t idx, logic [10:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		sb.set_reg(idx, d);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup(logic [10:0] mode, logic [10:0] nr, logic [10:0] nc,
			logic [10:0] kh, logic [10:0] kw);
		write_reg(REG_SHAPE_MODE, mode);
		write_reg(REG_IMAGE_ROWS, nr);
		write_reg(REG_IMAGE_COLS, nc);
		write_reg(REG_KERNEL_HEIGHT, kh);
		write_reg(REG_KERNEL_WIDTH, kw);
	endtask

	task automatic send(logic act, logic [4:0] idx, logic signed [15:0] cv,
			logic signed [15:0] smp);
		int gap;
		gap = send_steady ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		coef_index <= idx;
		coef_value <= cv;
		sample <= smp;
		do @(posedge clk); while (full);
		item_count++;
	endtask

	// stop sending and let the unit drain before touching registers
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_frame();
		int n;
		n = sb.fit(sb.regs[REG_IMAGE_ROWS], ROWS_MAX) * sb.fit(sb.regs[REG_IMAGE_COLS], COLS_MAX);
		for (int i = 0; i < n; i++) send(1'b1, 5'd0, 16'($urandom), 16'($urandom));
	endtask

	initial begin
		int nc;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every coefficient is written before any sample is taken
		setup(SHAPE_FULL, 11'd2, 11'd3, 11'd2, 11'd2);
		for (int i = 0; i < KMAX*KMAX; i++)
			send(1'b0, 5'(i), (i == 0) ? -16'sd32768 : (i == 1) ? 16'sd32767 : 16'($urandom),
				16'($urandom));
		send(1'b0, 5'd31, 16'sh7fff, 16'sd0);
		send(1'b1, 5'd0, 16'sd0, 16'sd32767);
		send(1'b1, 5'd0, 16'sd0, -16'sd32768);
		send(1'b1, 5'd0, 16'sd0, 16'sd32767);
		send(1'b1, 5'd0, 16'sd0, -16'sd32768);
		send(1'b1, 5'd0, 16'sd0, 16'sd32767);
		send(1'b1, 5'd0, 16'sd0, -16'sd1);
		drain();

		// oversized registers saturate; a partial frame then restarts at the origin
		setup(11'd3, 11'd2047, 11'd0, 11'd0, 11'd0);
		for (int i = 0; i < 3; i++) send(1'b1, 5'd0, 16'sd0, 16'($urandom));
		drain();
		write_reg(REG_IMAGE_ROWS, 11'd3);
		send_frame();
		drain();
		setup(SHAPE_VALID, 11'd2, 11'd2, 11'd7, 11'd3);
		send_frame();
		drain();

		while (item_count < 225) begin
			send_steady = ($urandom_range(0, 3) == 0);
			pop_steady = ($urandom_range(0, 3) == 0);
			nc = $urandom_range(0, 9);
			setup(11'($urandom_range(0, 3)),
				11'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6)),
				11'((nc > 8) ? 1024 : nc),
				11'($urandom_range(0, 7)), 11'($urandom_range(0, 7)));
			if (nc > 8) begin
				// one wide image, kept to a single row
				write_reg(REG_IMAGE_ROWS, 11'd1);
				write_reg(REG_KERNEL_HEIGHT, 11'd1);
			end
			if ($urandom_range(0, 2) == 0)
				for (int i = $urandom_range(1, 6); i > 0; i--)
					send(1'b0, 5'($urandom_range(0, 31)), 16'($urandom), 16'($urandom));
			if (nc > 8) begin
				// only the start of the wide row, the rest of the frame is left open
				for (int i = 0; i < 16; i++) send(1'b1, 5'd0, 16'($urandom), 16'($urandom));
			end else begin
				send_frame();
			end
			drain();
		end
		pop_steady = 1'b0;

		if (sb.fails == 0 && sb.pending.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
